/* rtl/tccur_pkg.sv */
// Package for the text console cursor engine.
// Holds the sizes, operation and character codes and the sweep unit types.
// No dependencies.
package tccur_pkg;

    localparam int MaxColumns = 32;
    localparam int MaxRows    = 24;
    localparam int ColW       = $clog2(MaxColumns);
    localparam int RowW       = $clog2(MaxRows);
    localparam int CurColW    = $clog2(MaxColumns + 1);
    localparam int AddrW      = RowW + ColW;
    localparam int Depth      = MaxColumns * MaxRows;
    localparam int CellW      = 16;

    localparam logic [1:0] OpPutChar = 2'd0;
    localparam logic [1:0] OpSetCell = 2'd1;
    localparam logic [1:0] OpFill    = 2'd2;
    localparam logic [1:0] OpReadCell = 2'd3;

    localparam logic [1:0] CfgColumns = 2'd0;
    localparam logic [1:0] CfgRows    = 2'd1;
    localparam logic [1:0] CfgRolling = 2'd2;

    localparam logic [7:0] CodeTab   = 8'd9;
    localparam logic [7:0] CodeNl    = 8'd10;
    localparam logic [7:0] CodeVt    = 8'd11;
    localparam logic [7:0] CodeCr    = 8'd13;
    localparam logic [7:0] CodeSpace = 8'd32;

    // Command to the sweep unit: walk rows row_first..row_end-1, columns 0..col_end-1.
    typedef struct packed {
        logic                 start;
        logic [RowW-1:0]      row_first;
        logic [RowW-1:0]      row_end;
        logic [CurColW-1:0]   col_end;
    } t_sweep_cmd;

    typedef struct packed {
        logic                 busy;
        logic                 last;
        logic [RowW-1:0]      row;
        logic [ColW-1:0]      col;
    } t_sweep_pos;

endpackage

/* rtl/tccur_cell_ram.sv */
// Cell store of the console: one write port, one read port with registered data.
// Depends on tccur_pkg.
module tccur_cell_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [tccur_pkg::AddrW-1:0]   i_waddr,
    input  logic [tccur_pkg::CellW-1:0]   i_wdata,
    input  logic                          i_re,
    input  logic [tccur_pkg::AddrW-1:0]   i_raddr,
    output logic [tccur_pkg::CellW-1:0]   o_rdata
);

    logic [tccur_pkg::CellW-1:0] r_mem [tccur_pkg::Depth];
    logic [tccur_pkg::CellW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tccur_sweep.sv */
// Shared address sweep unit: steps one cell per cycle across a rectangle of rows.
// Used for the clearing pass, fill and both scroll phases. Depends on tccur_pkg.
module tccur_sweep (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tccur_pkg::t_sweep_cmd   i_cmd,
    output tccur_pkg::t_sweep_pos   o_pos
);

    logic                              r_busy;
    logic [tccur_pkg::RowW-1:0]        r_row;
    logic [tccur_pkg::ColW-1:0]        r_col;
    logic [tccur_pkg::RowW-1:0]        r_row_end;
    logic [tccur_pkg::CurColW-1:0]     r_col_end;
    logic                              col_last;
    logic                              row_last;

    assign col_last = ({1'b0, r_col} + tccur_pkg::CurColW'(1)) == r_col_end;
    assign row_last = (r_row + tccur_pkg::RowW'(1)) == r_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && col_last && row_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row     <= i_cmd.row_first;
            r_col     <= '0;
            r_row_end <= i_cmd.row_end;
            r_col_end <= i_cmd.col_end;
        end else if (r_busy) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= r_row + tccur_pkg::RowW'(1);
            end else begin
                r_col <= r_col + tccur_pkg::ColW'(1);
            end
        end
    end

    assign o_pos.busy = r_busy;
    assign o_pos.last = r_busy && col_last && row_last;
    assign o_pos.row  = r_row;
    assign o_pos.col  = r_col;

endmodule

/* rtl/text_console_cursor_engine_top.sv */
// Top level of the text console cursor engine: sequencer, cursor and config registers.
// Depends on tccur_pkg, tccur_cell_ram and tccur_sweep.
//
//  Channel   Direction  Handshake               Payload
//  ------    ---------  ----------------------  ------------------------------------------
//  input     in         i_in_valid / o_in_stall  operation, character, attribute,
//                                                flush_on_scroll, cell_column, cell_row
//  result    out        o_out_valid / i_out_stall read_character, read_attribute,
//                                                cursor_column, cursor_row, flush_request
//  config    in         i_cfg_we (no wait)       i_cfg_index, i_cfg_data
//
// Each transaction is worked on alone, and o_in_stall stays high until its result has been
// loaded into the output register. A put_char that scrolls copies rows-1 rows up, then
// blanks the last active row, with a drain state between the two when more than one row
// is active, since the shared sweep unit moves one cell per cycle through the single write
// port of the cell store. Fill sweeps every active cell the same way; a read_cell whose
// row lies past the store skips the read wait.
// After reset the cell store is cleared one cell per cycle while input is stalled;
// configuration writes are taken during that time.
// A result waits in the output register while i_out_stall is high; the next transaction is
// still accepted and only its final load waits for the register to drain.
module text_console_cursor_engine_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_operation,
    input  logic [7:0]                         i_character,
    input  logic [7:0]                         i_attribute,
    input  logic                               i_flush_on_scroll,
    input  logic [4:0]                         i_cell_column,
    input  logic [4:0]                         i_cell_row,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_read_character,
    output logic [7:0]                         o_read_attribute,
    output logic [5:0]                         o_cursor_column,
    output logic [4:0]                         o_cursor_row,
    output logic                               o_flush_request,

    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [5:0]                         i_cfg_data
);

    localparam int RowW    = tccur_pkg::RowW;
    localparam int ColW    = tccur_pkg::ColW;
    localparam int CurColW = tccur_pkg::CurColW;
    localparam int AddrW   = tccur_pkg::AddrW;
    localparam int CellW   = tccur_pkg::CellW;

    localparam logic [3:0] S_CSTART = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_IDLE   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_FILL   = 4'd4;
    localparam logic [3:0] S_SCOPY  = 4'd5;
    localparam logic [3:0] S_SDRAIN = 4'd6;
    localparam logic [3:0] S_SBLANK = 4'd7;
    localparam logic [3:0] S_PLACE  = 4'd8;
    localparam logic [3:0] S_RWAIT  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // Configuration registers.
    logic [CurColW-1:0]   r_cfg_cols;
    logic [RowW-1:0]      r_cfg_rows;
    logic                 r_cfg_roll;

    // Effective sizes after clamping the register values.
    logic [CurColW-1:0]   eff_w;
    logic [RowW-1:0]      eff_h;

    // Sequencer and captured transaction.
    logic [3:0]           r_state, n_state;
    logic [1:0]           r_op;
    logic [7:0]           r_ch;
    logic [7:0]           r_attr;
    logic                 r_fl;
    logic [ColW-1:0]      r_ccol;
    logic [RowW-1:0]      r_crow;
    logic [CurColW-1:0]   r_w;
    logic [RowW-1:0]      r_h;
    logic                 r_roll;

    // Cursor and result.
    logic [CurColW-1:0]   r_col, n_col;
    logic [RowW-1:0]      r_row, n_row;
    logic                 r_flush, n_flush;
    logic [7:0]           r_res_ch;
    logic [7:0]           r_res_attr;

    // Output register.
    logic                 r_out_valid;
    logic [7:0]           r_out_ch;
    logic [7:0]           r_out_attr;
    logic [CurColW-1:0]   r_out_col;
    logic [RowW-1:0]      r_out_row;
    logic                 r_out_flush;

    // Pending copy write of the scroll pipeline.
    logic                 r_cp_valid;
    logic [AddrW-1:0]     r_cp_addr;

    // Memory ports.
    logic                 ram_we;
    logic [AddrW-1:0]     ram_waddr;
    logic [CellW-1:0]     ram_wdata;
    logic                 ram_re;
    logic [AddrW-1:0]     ram_raddr;
    logic [CellW-1:0]     ram_rdata;

    tccur_pkg::t_sweep_cmd sweep_cmd;
    tccur_pkg::t_sweep_pos sweep_pos;

    // Character classes and the put_char cursor move before the bottom rule.
    logic                 is_nl;
    logic                 is_vt;
    logic                 is_tab;
    logic                 printable;
    logic                 wrap;
    logic                 advance;
    logic [RowW:0]        row1;
    logic [CurColW-1:0]   col1;
    logic                 passed;
    logic                 in_accept;
    logic                 out_free;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_cfg_cols == '0) begin
            eff_w = CurColW'(1);
        end else if (r_cfg_cols > CurColW'(tccur_pkg::MaxColumns)) begin
            eff_w = CurColW'(tccur_pkg::MaxColumns);
        end else begin
            eff_w = r_cfg_cols;
        end
        if (r_cfg_rows == '0) begin
            eff_h = RowW'(1);
        end else if (r_cfg_rows > RowW'(tccur_pkg::MaxRows)) begin
            eff_h = RowW'(tccur_pkg::MaxRows);
        end else begin
            eff_h = r_cfg_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CurColW'(tccur_pkg::MaxColumns);
            r_cfg_rows <= RowW'(tccur_pkg::MaxRows);
            r_cfg_roll <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tccur_pkg::CfgColumns: r_cfg_cols <= i_cfg_data[CurColW-1:0];
                tccur_pkg::CfgRows:    r_cfg_rows <= i_cfg_data[RowW-1:0];
                tccur_pkg::CfgRolling: r_cfg_roll <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign is_nl     = (r_ch == tccur_pkg::CodeNl) || (r_ch == tccur_pkg::CodeCr);
    assign is_vt     = (r_ch == tccur_pkg::CodeVt);
    assign is_tab    = (r_ch == tccur_pkg::CodeTab);
    assign printable = !is_nl && !is_vt && !is_tab;
    assign wrap      = printable && (r_col >= r_w);
    assign advance   = is_nl || is_vt || wrap;
    assign row1      = {1'b0, r_row} + {{RowW{1'b0}}, advance};
    assign col1      = (is_nl || wrap) ? '0 : r_col;
    assign passed    = row1 >= {1'b0, r_h};

    // Sequencer: next state, cursor, memory ports and sweep commands.
    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_flush   = r_flush;
        ram_we    = 1'b0;
        ram_waddr = r_cp_addr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = {sweep_pos.row, sweep_pos.col};
        sweep_cmd.start     = 1'b0;
        sweep_cmd.row_first = '0;
        sweep_cmd.row_end   = r_h;
        sweep_cmd.col_end   = r_w;

        // The copy write follows its read in the next cycle.
        if (r_cp_valid) begin
            ram_we = 1'b1;
        end

        case (r_state)
            S_CSTART: begin
                sweep_cmd.start   = 1'b1;
                sweep_cmd.row_end = RowW'(tccur_pkg::MaxRows);
                sweep_cmd.col_end = CurColW'(tccur_pkg::MaxColumns);
                n_state = S_CLEAR;
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = {sweep_pos.row, sweep_pos.col};
                ram_wdata = '0;
                if (sweep_pos.last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_DECIDE;
                    n_flush = 1'b0;
                end
            end
            S_DECIDE: begin
                case (r_op)
                    tccur_pkg::OpPutChar: begin
                        n_col   = col1;
                        n_flush = passed && r_fl;
                        if (passed && !r_roll) begin
                            n_row = r_h - RowW'(1);
                            sweep_cmd.start = 1'b1;
                            if (r_h == RowW'(1)) begin
                                // A single row has nothing to copy: only blank it.
                                sweep_cmd.row_first = '0;
                                n_state = S_SBLANK;
                            end else begin
                                sweep_cmd.row_first = RowW'(1);
                                n_state = S_SCOPY;
                            end
                        end else begin
                            n_row   = passed ? '0 : row1[RowW-1:0];
                            n_state = printable ? S_PLACE : S_DONE;
                        end
                    end
                    tccur_pkg::OpSetCell: begin
                        if (r_crow < RowW'(tccur_pkg::MaxRows)) begin
                            ram_we    = 1'b1;
                            ram_waddr = {r_crow, r_ccol};
                            ram_wdata = {r_attr, r_ch};
                        end
                        n_state = S_DONE;
                    end
                    tccur_pkg::OpFill: begin
                        sweep_cmd.start = 1'b1;
                        n_flush = 1'b1;
                        n_state = S_FILL;
                    end
                    tccur_pkg::OpReadCell: begin
                        if (r_crow < RowW'(tccur_pkg::MaxRows)) begin
                            ram_re    = 1'b1;
                            ram_raddr = {r_crow, r_ccol};
                            n_state   = S_RWAIT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = {sweep_pos.row, sweep_pos.col};
                ram_wdata = {r_attr, r_ch};
                if (sweep_pos.last) begin
                    n_state = S_DONE;
                end
            end
            S_SCOPY: begin
                ram_re = 1'b1;
                if (sweep_pos.last) begin
                    n_state = S_SDRAIN;
                end
            end
            S_SDRAIN: begin
                // The last copy write happens here while the blanking sweep starts.
                sweep_cmd.start     = 1'b1;
                sweep_cmd.row_first = r_h - RowW'(1);
                n_state = S_SBLANK;
            end
            S_SBLANK: begin
                ram_we    = 1'b1;
                ram_waddr = {sweep_pos.row, sweep_pos.col};
                ram_wdata = {8'h00, tccur_pkg::CodeSpace};
                if (sweep_pos.last) begin
                    n_state = printable ? S_PLACE : S_DONE;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = {r_row, r_col[ColW-1:0]};
                ram_wdata = {r_attr, r_ch};
                n_col     = r_col + CurColW'(1);
                n_state   = S_DONE;
            end
            S_RWAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CSTART;
            r_col      <= '0;
            r_row      <= '0;
            r_flush    <= 1'b0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_flush    <= n_flush;
            r_cp_valid <= (r_state == S_SCOPY);
        end
    end

    // Copy destination is the row above the cell being read.
    always_ff @(posedge i_clk) begin
        r_cp_addr <= {sweep_pos.row - RowW'(1), sweep_pos.col};
    end

    // Transaction capture; sizes are frozen for the whole transaction.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_operation;
            r_ch   <= i_character;
            r_attr <= i_attribute;
            r_fl   <= i_flush_on_scroll;
            r_ccol <= i_cell_column;
            r_crow <= i_cell_row;
            r_w    <= eff_w;
            r_h    <= eff_h;
            r_roll <= r_cfg_roll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res_ch   <= '0;
            r_res_attr <= '0;
        end else if (r_state == S_RWAIT) begin
            r_res_ch   <= ram_rdata[7:0];
            r_res_attr <= ram_rdata[15:8];
        end
    end

    // Output register: loaded when the transaction is done and the register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_ch    <= r_res_ch;
            r_out_attr  <= r_res_attr;
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_flush <= r_flush;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_character = r_out_ch;
    assign o_read_attribute = r_out_attr;
    assign o_cursor_column  = r_out_col;
    assign o_cursor_row     = r_out_row;
    assign o_flush_request  = r_out_flush;

    tccur_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tccur_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (sweep_cmd),
        .o_pos   (sweep_pos)
    );

    // A put_char always leaves the cursor row inside the active height.
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_op == tccur_pkg::OpPutChar) |-> (r_row < r_h))
        else $error("cursor row left outside active height after put_char");

    // The scroll pipeline never writes the cell it is reading in the same cycle.
    a_copy_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cp_valid && ram_re) |-> (r_cp_addr != ram_raddr))
        else $error("scroll copy write collides with its read");

    // The sweep unit runs only in states that consume its addresses.
    a_sweep_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_pos.busy |-> (r_state == S_CLEAR || r_state == S_FILL ||
                            r_state == S_SCOPY || r_state == S_SBLANK))
        else $error("sweep unit busy outside a sweeping state");

    // A copy write is pending only right after a copy read.
    a_copy_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> ($past(r_state) == S_SCOPY))
        else $error("copy write without a preceding copy read");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for text_console_cursor_engine_top: a directed script, then
// randomized phases over many screen sizes, checked against a behavioral model or hand-written results.
// Depends on tccur_pkg and the text console cursor engine RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [1:0] CfgSpare = 2'd3;

    localparam int RandomItems   = 755;
    localparam int WatchdogLimit = 10000;
    // A full-screen scroll or fill is the slowest transaction.
    localparam int DrainCycles   = 800;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       flush;
        logic [4:0] col;
        logic [4:0] row;
    } t_console_cmd;

    typedef struct packed {
        logic [7:0] rd_char;
        logic [7:0] rd_attr;
        logic [5:0] cur_col;
        logic [4:0] cur_row;
        logic       flush;
    } t_console_result;

    // One line of the directed script. A line may carry a register setting that is applied
    // once the engine has gone idle, and a hand-written result that replaces the model's.
    typedef struct packed {
        logic            reconfig;
        logic [5:0]      cfg_cols;
        logic [5:0]      cfg_rows;
        logic [5:0]      cfg_mode;
        t_console_cmd    cmd;
        logic            typed;
        t_console_result want;
    } t_script_line;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] in_operation = tccur_pkg::OpPutChar;
    logic [7:0] in_character = 8'h00;
    logic [7:0] in_attribute = 8'h00;
    logic       in_flush_on_scroll = 1'b0;
    logic [4:0] in_cell_column = 5'd0;
    logic [4:0] in_cell_row = 5'd0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_read_character;
    logic [7:0] out_read_attribute;
    logic [5:0] out_cursor_column;
    logic [4:0] out_cursor_row;
    logic       out_flush_request;

    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = tccur_pkg::CfgColumns;
    logic [5:0] cfg_data = 6'd0;

    text_console_cursor_engine_top u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (in_operation),
        .i_character       (in_character),
        .i_attribute       (in_attribute),
        .i_flush_on_scroll (in_flush_on_scroll),
        .i_cell_column     (in_cell_column),
        .i_cell_row        (in_cell_row),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_read_character  (out_read_character),
        .o_read_attribute  (out_read_attribute),
        .o_cursor_column   (out_cursor_column),
        .o_cursor_row      (out_cursor_row),
        .o_flush_request   (out_flush_request),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------------------
    // Console model: its own copy of the screen, the cursor and the three registers.
    // ------------------------------------------------------------------------------------
    logic [15:0] screen_cells [tccur_pkg::MaxRows][tccur_pkg::MaxColumns];
    int          cur_col;
    int          cur_row;
    logic [5:0]  reg_columns;
    logic [4:0]  reg_rows;
    logic        reg_rolling;

    t_console_result results_due[$];
    t_script_line    script_lines[$];
    int              mismatch_count = 0;

    // Zero and oversized register values clamp to the legal range.
    function automatic int span_columns();
        if (reg_columns == 0) return 1;
        if (reg_columns > tccur_pkg::MaxColumns) return tccur_pkg::MaxColumns;
        return int'(reg_columns);
    endfunction

    function automatic int span_rows();
        if (reg_rows == 0) return 1;
        if (reg_rows > tccur_pkg::MaxRows) return tccur_pkg::MaxRows;
        return int'(reg_rows);
    endfunction

    function automatic void store_char(int c, int r, logic [7:0] ch, logic [7:0] attr);
        if (c >= tccur_pkg::MaxColumns || r >= tccur_pkg::MaxRows) return;
        screen_cells[r][c] = {attr, ch};
    endfunction

    // Bottom rule: a cursor row at or past the active height either rolls to the top or
    // scrolls the active area up one line and blanks the last line. Returns 1 when taken.
    function automatic bit bottom_rule(int w, int h);
        if (cur_row < h) return 1'b0;
        if (reg_rolling) begin
            cur_row = 0;
        end else begin
            for (int r = 1; r < h; r++)
                for (int c = 0; c < w; c++)
                    screen_cells[r-1][c] = screen_cells[r][c];
            for (int c = 0; c < w; c++)
                store_char(c, h - 1, tccur_pkg::CodeSpace, 8'h00);
            cur_row = h - 1;
        end
        return 1'b1;
    endfunction

    function automatic t_console_result step_console(t_console_cmd cmd);
        t_console_result res;
        int w;
        int h;
        bit passed;
        w = span_columns();
        h = span_rows();
        res = '0;
        passed = 1'b0;
        case (cmd.op)
            tccur_pkg::OpPutChar: begin
                if (cmd.ch == tccur_pkg::CodeNl || cmd.ch == tccur_pkg::CodeCr) begin
                    cur_row++;
                    cur_col = 0;
                    passed = bottom_rule(w, h);
                end else if (cmd.ch == tccur_pkg::CodeVt) begin
                    cur_row++;
                    passed = bottom_rule(w, h);
                end else if (cmd.ch == tccur_pkg::CodeTab) begin
                    // A tab stores and moves nothing, yet a cursor left below the area
                    // by a shrink is still brought back.
                    passed = bottom_rule(w, h);
                end else begin
                    // Wrap first, then settle the bottom, then place the character.
                    if (cur_col >= w) begin
                        cur_col = 0;
                        cur_row++;
                    end
                    passed = bottom_rule(w, h);
                    store_char(cur_col, cur_row, cmd.ch, cmd.attr);
                    cur_col++;
                end
                res.flush = passed && cmd.flush;
            end
            tccur_pkg::OpSetCell: begin
                store_char(cmd.col, cmd.row, cmd.ch, cmd.attr);
            end
            tccur_pkg::OpFill: begin
                for (int r = 0; r < h; r++)
                    for (int c = 0; c < w; c++)
                        store_char(c, r, cmd.ch, cmd.attr);
                res.flush = 1'b1;
            end
            default: begin
                // Every 5-bit column is on the screen; only the row can fall outside.
                if (cmd.row < tccur_pkg::MaxRows)
                    {res.rd_attr, res.rd_char} = screen_cells[cmd.row][cmd.col];
            end
        endcase
        res.cur_col = 6'(cur_col);
        res.cur_row = 5'(cur_row);
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Directed script builders.
    // ------------------------------------------------------------------------------------
    logic       retune_pending = 1'b0;
    logic [5:0] retune_cols;
    logic [5:0] retune_rows;
    logic [5:0] retune_mode;

    function automatic void retune(logic [5:0] cols, logic [5:0] rows, logic [5:0] mode);
        retune_pending = 1'b1;
        retune_cols = cols;
        retune_rows = rows;
        retune_mode = mode;
    endfunction

    function automatic void plan(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
                                 logic fl, logic [4:0] col, logic [4:0] row);
        t_script_line line;
        line = '0;
        line.reconfig = retune_pending;
        line.cfg_cols = retune_cols;
        line.cfg_rows = retune_rows;
        line.cfg_mode = retune_mode;
        line.cmd = {op, ch, attr, fl, col, row};
        retune_pending = 1'b0;
        script_lines.push_back(line);
    endfunction

    // Attaches a hand-written result to the line planned last.
    function automatic void known(logic [7:0] rc, logic [7:0] ra, logic [5:0] cc,
                                  logic [4:0] cr, logic fr);
        script_lines[script_lines.size()-1].typed = 1'b1;
        script_lines[script_lines.size()-1].want = {rc, ra, cc, cr, fr};
    endfunction

    // ------------------------------------------------------------------------------------
    // Random helpers.
    // ------------------------------------------------------------------------------------
    function automatic int idle_length();
        int dice;
        dice = $urandom_range(0, 99);
        if (dice < 80) return $urandom_range(1, 3);
        if (dice < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Addresses mostly land in the active area; one in five covers the whole 5-bit range,
    // rows past the store included.
    function automatic t_console_cmd random_cmd(int w, int h, int put_pct, int ctrl_pct);
        t_console_cmd c;
        int dice;
        c.ch = 8'($urandom_range(0, 255));
        c.attr = 8'($urandom_range(0, 255));
        c.flush = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
            c.col = 5'($urandom_range(0, 31));
            c.row = 5'($urandom_range(0, 31));
        end else begin
            c.col = 5'($urandom_range(0, w - 1));
            c.row = 5'($urandom_range(0, h - 1));
        end
        if ($urandom_range(0, 99) < put_pct) begin
            c.op = tccur_pkg::OpPutChar;
            if ($urandom_range(0, 99) < ctrl_pct) begin
                case ($urandom_range(0, 3))
                    0: c.ch = tccur_pkg::CodeNl;
                    1: c.ch = tccur_pkg::CodeCr;
                    2: c.ch = tccur_pkg::CodeVt;
                    default: c.ch = tccur_pkg::CodeTab;
                endcase
            end
        end else begin
            dice = $urandom_range(0, 99);
            if (dice < 35) c.op = tccur_pkg::OpSetCell;
            else if (dice < 45) c.op = tccur_pkg::OpFill;
            else c.op = tccur_pkg::OpReadCell;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------------------
    // Stimulus tasks. All of them are entered and left just after a rising edge.
    // ------------------------------------------------------------------------------------

    // Presents one transaction, waits for the engine to take it, then files the result it
    // must produce: the hand-written one where given, the model's otherwise. The model
    // always runs so that its screen keeps up.
    task automatic send_item(input t_console_cmd cmd, input bit typed,
                             input t_console_result want);
        t_console_result model;
        in_valid <= 1'b1;
        in_operation <= cmd.op;
        in_character <= cmd.ch;
        in_attribute <= cmd.attr;
        in_flush_on_scroll <= cmd.flush;
        in_cell_column <= cmd.col;
        in_cell_row <= cmd.row;
        do @(posedge clk); while (in_stall !== 1'b0);
        model = step_console(cmd);
        results_due.push_back(typed ? want : model);
    endtask

    // Sender idling: 55 percent of the transactions follow back to back when idling is on.
    task automatic pace(input bit idle_on);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) >= 55) ? idle_length() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every result due has been taken. The queue is polled on
    // the falling edge so that a pop at the rising edge is always seen.
    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge clk);
        @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Writes all three registers plus the unused index, one per cycle.
    task automatic apply_config(input logic [5:0] cols, input logic [5:0] rows,
                                input logic [5:0] mode);
        cfg_we <= 1'b1;
        cfg_index <= tccur_pkg::CfgColumns;
        cfg_data <= cols;
        @(posedge clk);
        reg_columns = cols;
        cfg_index <= tccur_pkg::CfgRows;
        cfg_data <= rows;
        @(posedge clk);
        reg_rows = rows[4:0];
        cfg_index <= tccur_pkg::CfgRolling;
        cfg_data <= mode;
        @(posedge clk);
        reg_rolling = mode[0];
        cfg_index <= CfgSpare;
        cfg_data <= 6'($urandom_range(0, 63));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------------------
    // Result checking: every accepted result is matched against the oldest one due.
    // ------------------------------------------------------------------------------------
    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin
        t_console_result due;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (results_due.size() == 0) begin
                $error("result transaction arrived with none outstanding");
                mismatch_count++;
            end else begin
                due = results_due.pop_front();
                check_field("read_character", due.rd_char, out_read_character);
                check_field("read_attribute", due.rd_attr, out_read_attribute);
                check_field("cursor_column", 8'(due.cur_col), 8'(out_cursor_column));
                check_field("cursor_row", 8'(due.cur_row), 8'(out_cursor_row));
                check_field("flush_request", 8'(due.flush), 8'(out_flush_request));
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Receiver stalls. The stall mode is redrawn periodically: no stalls, light or heavy.
    // Stall bursts are mostly short, now and then much longer.
    // ------------------------------------------------------------------------------------
    int hold_cycles = 0;
    int hold_mode = 1;
    int hold_left = 0;

    always @(posedge clk) begin
        hold_cycles++;
        if (hold_cycles % 300 == 0) hold_mode = $urandom_range(0, 2);
        if (hold_left > 0) hold_left--;
        else if (hold_mode != 0 && $urandom_range(0, 99) < 25 * hold_mode)
            hold_left = idle_length();
        out_stall <= (hold_left > 0);
    end

    // ------------------------------------------------------------------------------------
    // Watchdog: too long without any transaction on either channel means a hang.
    // ------------------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------------------
    initial begin
        int         random_sent;
        int         phase;
        int         batch;
        int         put_pct;
        int         ctrl_pct;
        bit         idle_on;
        logic [5:0] d_cols;
        logic [5:0] d_rows;
        logic [5:0] d_mode;

        for (int r = 0; r < tccur_pkg::MaxRows; r++)
            for (int c = 0; c < tccur_pkg::MaxColumns; c++)
                screen_cells[r][c] = 16'h0000;
        cur_col = 0;
        cur_row = 0;
        reg_columns = 6'd32;
        reg_rows = 5'd24;
        reg_rolling = 1'b0;

        // Directed script. The first part runs on the reset settings: 32 by 24, scrolling.
        // A cleared store reads back zero, also past the last row.
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd0, 5'd0);
        known(8'h00, 8'h00, 6'd0, 5'd0, 1'b0);
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd31, 5'd31);
        known(8'h00, 8'h00, 6'd0, 5'd0, 1'b0);
        // Far corner with all ones, then a write past the last row that must not alias.
        plan(tccur_pkg::OpSetCell, 8'hFF, 8'hFF, 1'b1, 5'd31, 5'd23);
        known(8'h00, 8'h00, 6'd0, 5'd0, 1'b0);
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd31, 5'd23);
        known(8'hFF, 8'hFF, 6'd0, 5'd0, 1'b0);
        plan(tccur_pkg::OpSetCell, 8'hAA, 8'h55, 1'b0, 5'd5, 5'd24);
        known(8'h00, 8'h00, 6'd0, 5'd0, 1'b0);
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd5, 5'd0);
        known(8'h00, 8'h00, 6'd0, 5'd0, 1'b0);
        // Printable characters, then each control code.
        plan(tccur_pkg::OpPutChar, 8'h41, 8'h12, 1'b0, 5'd0, 5'd0);
        known(8'h00, 8'h00, 6'd1, 5'd0, 1'b0);
        plan(tccur_pkg::OpPutChar, 8'h00, 8'h00, 1'b1, 5'd31, 5'd31);
        plan(tccur_pkg::OpPutChar, tccur_pkg::CodeTab, 8'h33, 1'b1, 5'd0, 5'd0);
        known(8'h00, 8'h00, 6'd2, 5'd0, 1'b0);
        plan(tccur_pkg::OpPutChar, tccur_pkg::CodeVt, 8'h00, 1'b1, 5'd0, 5'd0);
        known(8'h00, 8'h00, 6'd2, 5'd1, 1'b0);
        plan(tccur_pkg::OpPutChar, tccur_pkg::CodeCr, 8'h00, 1'b0, 5'd0, 5'd0);
        known(8'h00, 8'h00, 6'd0, 5'd2, 1'b0);
        plan(tccur_pkg::OpPutChar, tccur_pkg::CodeNl, 8'h00, 1'b1, 5'd0, 5'd0);
        known(8'h00, 8'h00, 6'd0, 5'd3, 1'b0);
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd0, 5'd0);
        known(8'h41, 8'h12, 6'd0, 5'd3, 1'b0);
        // Fill flushes and leaves the cursor alone.
        plan(tccur_pkg::OpFill, 8'h2E, 8'h07, 1'b0, 5'd0, 5'd0);
        known(8'h00, 8'h00, 6'd0, 5'd3, 1'b1);
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd31, 5'd23);
        known(8'h2E, 8'h07, 6'd0, 5'd3, 1'b0);
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd1, 5'd0);
        plan(tccur_pkg::OpPutChar, 8'hFF, 8'h80, 1'b0, 5'd0, 5'd0);
        // Zero registers act as a one-cell screen; the cursor now sits outside it, so the
        // next character wraps, scrolls and is then placed on the last row.
        retune(6'd0, 6'd0, 6'd0);
        plan(tccur_pkg::OpPutChar, 8'h7E, 8'hFF, 1'b1, 5'd0, 5'd0);
        plan(tccur_pkg::OpPutChar, tccur_pkg::CodeNl, 8'h00, 1'b0, 5'd0, 5'd0);
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd0, 5'd0);
        // Oversized width clamps to the maximum; two rows with rolling.
        retune(6'd63, 6'd2, 6'd1);
        plan(tccur_pkg::OpPutChar, tccur_pkg::CodeNl, 8'h00, 1'b1, 5'd0, 5'd0);
        plan(tccur_pkg::OpPutChar, tccur_pkg::CodeVt, 8'h00, 1'b1, 5'd0, 5'd0);
        plan(tccur_pkg::OpPutChar, 8'h42, 8'h01, 1'b1, 5'd0, 5'd0);
        // Oversized height clamps to the maximum, with bit 5 of the data set.
        retune(6'd32, 6'h3F, 6'h3E);
        plan(tccur_pkg::OpReadCell, 8'h00, 8'h00, 1'b0, 5'd31, 5'd23);
        plan(tccur_pkg::OpPutChar, tccur_pkg::CodeTab, 8'h00, 1'b1, 5'd0, 5'd0);

        // Synchronous reset first; the engine then clears its store on its own.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script_lines[k]) begin
            if (script_lines[k].reconfig) begin
                wait_drained(2);
                apply_config(script_lines[k].cfg_cols, script_lines[k].cfg_rows,
                             script_lines[k].cfg_mode);
            end
            send_item(script_lines[k].cmd, script_lines[k].typed, script_lines[k].want);
            pace(1'b1);
        end

        // Random phases. Each draws a screen size; most are small so that scrolls stay
        // cheap, every eighth uses the full store and is biased toward line feeds so that
        // full-size scrolls happen. The cursor carries over, so shrinking leaves it outside.
        random_sent = 0;
        phase = 0;
        while (random_sent < RandomItems) begin
            batch = 40;
            put_pct = 60;
            ctrl_pct = 30;
            if (phase % 8 == 0) begin
                d_cols = $urandom_range(0, 1) ? 6'd32 : 6'($urandom_range(33, 63));
                d_rows = {1'($urandom_range(0, 1)),
                          ($urandom_range(0, 1) ? 5'd24 : 5'($urandom_range(25, 31)))};
                put_pct = 85;
                ctrl_pct = 90;
            end else if ($urandom_range(0, 5) == 0) begin
                // Degenerate screens: zero or one column and row.
                d_cols = 6'($urandom_range(0, 1));
                d_rows = {1'($urandom_range(0, 1)), 5'($urandom_range(0, 1))};
                batch = 30;
            end else if ($urandom_range(0, 4) == 0) begin
                // Wide and shallow: long lines, cheap scrolls.
                d_cols = 6'($urandom_range(9, 32));
                d_rows = {1'($urandom_range(0, 1)), 5'($urandom_range(1, 3))};
            end else begin
                d_cols = 6'($urandom_range(1, 8));
                d_rows = {1'($urandom_range(0, 1)), 5'($urandom_range(1, 6))};
            end
            d_mode = 6'($urandom_range(0, 63));
            idle_on = ($urandom_range(0, 3) != 0);

            wait_drained(2);
            apply_config(d_cols, d_rows, d_mode);

            for (int n = 0; n < batch && random_sent < RandomItems; n++) begin
                send_item(random_cmd(span_columns(), span_rows(), put_pct, ctrl_pct),
                          1'b0, '0);
                random_sent++;
                // Now and then the sender waits for the engine to empty out completely.
                if ($urandom_range(0, 99) == 0) wait_drained(0);
                else pace(idle_on);
            end
            phase++;
        end

        wait_drained(DrainCycles);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tccur_pkg.sv
rtl/tccur_cell_ram.sv
rtl/tccur_sweep.sv
rtl/text_console_cursor_engine_top.sv
verif/tb_top.sv
